/* rtl/mi4_pkg.sv */
// Shared widths, defaults and index helpers for the 4x4 matrix inverse.
// Depends on nothing; imported by matrix_inverse_4x4.
package mi4_pkg;

    localparam int EW             = 32;            // stored element width
    localparam int CH_W           = 32;            // multiplier chunk width
    localparam int PROD_W         = 2 * CH_W + 2;  // 33x33 signed product
    localparam int MIN_W          = 2 * EW + 1;    // 2x2 minor
    localparam int ADJ_W          = 3 * EW + 3;    // cofactor (3x3 minor)
    localparam int DET_W          = 4 * EW + 5;    // determinant
    localparam int NCH_M          = (MIN_W + CH_W - 1) / CH_W;
    localparam int NCH_A          = (ADJ_W + CH_W - 1) / CH_W;
    localparam int XR_W           = NCH_A * CH_W;
    localparam int IDX_W          = 4;
    localparam int USER_W         = IDX_W + 2;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_DATA_WIDTH = 32;

    typedef logic [EW-1:0] t_elem;

    // position t of the three indexes 0..3 that remain once s is removed
    function automatic logic [1:0] skip_sel(input logic [1:0] t, input logic [1:0] s);
        logic [1:0] bump;
        bump = (t >= s) ? 2'd1 : 2'd0;
        return t + bump;
    endfunction

endpackage

/* rtl/matrix_inverse_4x4.sv */
// 4x4 matrix inverse by cofactors, Q-format fixed point.
// Depends on mi4_pkg (widths, defaults, index helper).
//
// Usage: sixteen words enter on s_axis in column-major order (element k is
// row k%4, column k/4). s_axis_tready is high only while a matrix is loading.
// After the sixteenth word the block forms the sixteen cofactors and the
// determinant with one shared 33x33 multiplier that reads the element store,
// then divides each cofactor by the determinant with a one-bit-per-cycle
// restoring divider. Sixteen words leave on m_axis, index in tuser, tlast on
// index 15; tuser also flags a singular matrix (identity returned) and a
// clamped value.
// The cofactor pass is paced by the single multiplier and the registered
// element memory read; the determinant pass follows, and the divider then
// forms OUT_W + 1 quotient bits per result. A new matrix is taken only once
// the last result word of the previous one has left on m_axis.
// Reset clears the load counter, the state machine, the loop indexes and the output valid; the stores need none.
// A stalled m_axis holds its word; no further work is done until it is taken.
module matrix_inverse_4x4
    import mi4_pkg::*;
#(
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [EW-1:0]     s_axis_tdata,   // [31:0] element_value
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [EW-1:0]     m_axis_tdata,   // [31:0] result_value
    output logic [USER_W-1:0] m_axis_tuser,   // [3:0] result_index, [4] singular,
                                              // [5] saturated
    output logic              m_axis_tlast    // last_result
);

    localparam int OUT_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int QB    = OUT_W + 1;
    localparam int Q_W   = OUT_W + 2;
    localparam int NUM_W = ADJ_W + 2 * FRAC_BITS;
    localparam int HI_W  = NUM_W - QB;
    localparam int CMP_W = ((HI_W > DET_W) ? HI_W : DET_W) + 1;
    localparam int CNT_W = $clog2(QB + 1);
    localparam logic [31:0] LIM_POS32 = 32'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic [31:0] LIM_NEG32 = ~LIM_POS32;
    localparam logic [Q_W-1:0] LIM_MAG = Q_W'(64'd1 << (OUT_W - 1));
    localparam logic ID_SAT = (FRAC_BITS >= OUT_W - 1);
    localparam logic [31:0] ID_VAL32 = ID_SAT ? LIM_POS32 : 32'(64'd1 << FRAC_BITS);

    typedef enum logic [3:0] {
        S_LOAD, S_RDE, S_RDX, S_LATX, S_MUL, S_ACC, S_NEXT,
        S_DRD, S_DLAT, S_DCHK, S_DIV, S_RND, S_OUT
    } t_state;

    typedef enum logic {PH_COF, PH_DET} t_phase;

    t_state              r_state;
    t_phase              r_phase;
    logic [IDX_W-1:0]    r_cnt;
    logic [IDX_W-1:0]    r_k;
    logic [1:0]          r_j;
    logic [1:0]          r_u;
    logic [1:0]          r_t;
    logic [1:0]          r_chunk;
    logic [1:0]          r_ch_last;
    t_elem               r_e;
    logic [XR_W-1:0]     r_x;
    logic [PROD_W-1:0]   r_prod;
    logic [MIN_W-1:0]    r_mn;
    logic [DET_W-1:0]    r_acc;
    logic [DET_W-1:0]    r_dabs;
    logic                r_det_neg;
    logic                r_sing;
    logic [ADJ_W-1:0]    r_num;
    logic                r_neg;
    logic [DET_W-1:0]    r_rem;
    logic [QB-1:0]       r_nlo;
    logic [QB-1:0]       r_q;
    logic [CNT_W-1:0]    r_i;
    logic                r_ovalid;
    logic [31:0]         r_odata;
    logic [IDX_W-1:0]    r_oidx;
    logic                r_olast;
    logic                r_osing;
    logic                r_osat;

    t_elem               r_mem [16];
    t_elem               r_mem_q;
    logic [ADJ_W-1:0]    r_adj_mem [16];
    logic [ADJ_W-1:0]    r_adj_q;

    logic                in_acc, out_acc;
    logic [1:0]          row0, row1, row2, jx, jy, colx, coly, colj;
    logic [IDX_W-1:0]    ea, xa, mem_ra, adj_ra;
    logic                mem_we, adj_we;
    logic [CH_W-1:0]     chunk;
    logic [CH_W:0]       op33, e33;
    logic [PROD_W-1:0]   mul_out;
    logic [DET_W-1:0]    term;
    logic [NUM_W-1:0]    numsh;
    logic [HI_W-1:0]     hi;
    logic                over_pre;
    logic [DET_W:0]      r2, d_ext, diff;
    logic                ge, up;
    logic [Q_W-1:0]      q1, lim, qmag;
    logic                over_rnd;
    logic [33:0]         mag34, neg34;
    logic [31:0]         rnd_val;
    logic                diag;

    assign s_axis_tready = (r_state == S_LOAD);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = r_ovalid && m_axis_tready;

    // sub-matrix indexes for cofactor k = c*4 + r: drop row c, column r
    assign row0 = skip_sel(2'd0, r_k[3:2]);
    assign row1 = skip_sel(2'd1, r_k[3:2]);
    assign row2 = skip_sel(2'd2, r_k[3:2]);
    assign jx   = (r_j == 2'd0) ? 2'd1 : 2'd0;
    assign jy   = (r_j == 2'd2) ? 2'd1 : 2'd2;
    assign colx = skip_sel(jx, r_k[1:0]);
    assign coly = skip_sel(jy, r_k[1:0]);
    assign colj = skip_sel(r_j, r_k[1:0]);

    always_comb begin
        ea = {2'd0, r_t};
        xa = {colx, row2};
        if (r_phase == PH_COF) begin
            case (r_u)
                2'd0:    ea = {colx, row1};
                2'd1:    ea = {coly, row1};
                default: ea = {colj, row0};
            endcase
            xa = (r_u == 2'd0) ? {coly, row2} : {colx, row2};
        end
    end

    assign mem_we = in_acc;
    assign mem_ra = (r_state == S_RDX) ? xa : ea;
    assign adj_ra = (r_phase == PH_DET && r_state != S_DRD) ? {r_t, 2'b00} : r_k;
    assign adj_we = (r_state == S_NEXT) && (r_phase == PH_COF) &&
                    (r_u == 2'd2) && (r_j == 2'd2);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_cnt] <= s_axis_tdata;
        end
        r_mem_q <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (adj_we) begin
            r_adj_mem[r_k] <= r_acc[ADJ_W-1:0];
        end
        r_adj_q <= r_adj_mem[adj_ra];
    end

    // shared multiplier: element times one 32-bit chunk, top chunk signed
    assign chunk   = r_x[{r_chunk, 5'b0} +: CH_W];
    assign op33    = (r_chunk == r_ch_last) ? {chunk[CH_W-1], chunk} : {1'b0, chunk};
    assign e33     = {r_e[EW-1], r_e};
    assign mul_out = PROD_W'($signed(e33)) * PROD_W'($signed(op33));
    assign term    = {{(DET_W-PROD_W){r_prod[PROD_W-1]}}, r_prod} << {r_chunk, 5'b0};

    // divider datapath
    assign numsh    = {r_num, (2 * FRAC_BITS)'(0)};
    assign hi       = numsh[NUM_W-1:QB];
    assign over_pre = CMP_W'(hi) >= CMP_W'(r_dabs);
    assign d_ext    = {1'b0, r_dabs};
    assign r2       = {r_rem, r_nlo[QB-1]};
    assign ge       = r2 >= d_ext;
    assign diff     = r2 - d_ext;
    assign up       = {r_rem, 1'b0} >= d_ext;
    assign q1       = Q_W'(r_q) + Q_W'(up);
    assign lim      = r_neg ? LIM_MAG : (LIM_MAG - Q_W'(1));
    assign over_rnd = q1 > lim;
    assign qmag     = over_rnd ? lim : q1;
    assign mag34    = 34'(qmag);
    assign neg34    = 34'd0 - mag34;
    assign rnd_val  = r_neg ? neg34[31:0] : mag34[31:0];
    assign diag     = (r_k[1:0] == r_k[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_phase  <= PH_COF;
            r_cnt    <= '0;
            r_k      <= '0;
            r_j      <= '0;
            r_u      <= '0;
            r_t      <= '0;
            r_chunk  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == IDX_W'(15)) begin
                            r_phase <= PH_COF;
                            r_k     <= '0;
                            r_j     <= '0;
                            r_u     <= '0;
                            r_acc   <= '0;
                            r_mn    <= '0;
                            r_state <= S_RDE;
                        end
                    end
                end
                S_RDE: begin
                    r_state <= S_RDX;
                end
                S_RDX: begin
                    r_e     <= r_mem_q;
                    r_state <= S_LATX;
                end
                S_LATX: begin
                    r_chunk <= '0;
                    if (r_phase == PH_DET) begin
                        r_x       <= {{(XR_W-ADJ_W){r_adj_q[ADJ_W-1]}}, r_adj_q};
                        r_ch_last <= 2'(NCH_A - 1);
                    end else if (r_u == 2'd2) begin
                        r_x       <= {{(XR_W-MIN_W){r_mn[MIN_W-1]}}, r_mn};
                        r_ch_last <= 2'(NCH_M - 1);
                    end else begin
                        r_x       <= {{(XR_W-EW){r_mem_q[EW-1]}}, r_mem_q};
                        r_ch_last <= 2'd0;
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= mul_out;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_phase == PH_COF && r_u != 2'd2) begin
                        // minor = a*d - b*c
                        if (r_u == 2'd1) begin
                            r_mn <= r_mn - r_prod[MIN_W-1:0];
                        end else begin
                            r_mn <= r_mn + r_prod[MIN_W-1:0];
                        end
                    end else if (r_phase == PH_COF &&
                                 (r_j[0] ^ r_k[0] ^ r_k[2])) begin
                        r_acc <= r_acc - term;
                    end else begin
                        r_acc <= r_acc + term;
                    end
                    r_chunk <= r_chunk + 1'b1;
                    r_state <= (r_chunk == r_ch_last) ? S_NEXT : S_MUL;
                end
                S_NEXT: begin
                    r_state <= S_RDE;
                    if (r_phase == PH_COF) begin
                        if (r_u != 2'd2) begin
                            r_u <= r_u + 1'b1;
                        end else begin
                            r_u  <= '0;
                            r_mn <= '0;
                            if (r_j != 2'd2) begin
                                r_j <= r_j + 1'b1;
                            end else begin
                                r_j   <= '0;
                                r_acc <= '0;
                                r_k   <= r_k + 1'b1;
                                if (r_k == IDX_W'(15)) begin
                                    r_phase <= PH_DET;
                                    r_t     <= '0;
                                end
                            end
                        end
                    end else if (r_t != 2'd3) begin
                        r_t <= r_t + 1'b1;
                    end else begin
                        r_det_neg <= r_acc[DET_W-1];
                        r_dabs    <= r_acc[DET_W-1] ? (DET_W'(0) - r_acc) : r_acc;
                        r_sing    <= (r_acc == '0);
                        r_phase   <= PH_COF;
                        r_k       <= '0;
                        r_state   <= S_DRD;
                    end
                end
                S_DRD: begin
                    r_state <= S_DLAT;
                end
                S_DLAT: begin
                    r_num   <= r_adj_q[ADJ_W-1] ? (ADJ_W'(0) - r_adj_q) : r_adj_q;
                    r_neg   <= r_adj_q[ADJ_W-1] ^ r_det_neg;
                    r_state <= S_DCHK;
                end
                S_DCHK: begin
                    r_oidx  <= r_k;
                    r_olast <= (r_k == IDX_W'(15));
                    r_osing <= r_sing;
                    if (r_sing) begin
                        r_odata  <= diag ? ID_VAL32 : 32'd0;
                        r_osat   <= diag && ID_SAT;
                        r_ovalid <= 1'b1;
                        r_state  <= S_OUT;
                    end else if (over_pre) begin
                        r_odata  <= r_neg ? LIM_NEG32 : LIM_POS32;
                        r_osat   <= 1'b1;
                        r_ovalid <= 1'b1;
                        r_state  <= S_OUT;
                    end else begin
                        r_rem   <= DET_W'(hi);
                        r_nlo   <= numsh[QB-1:0];
                        r_q     <= '0;
                        r_i     <= CNT_W'(QB);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem   <= ge ? diff[DET_W-1:0] : r2[DET_W-1:0];
                    r_q     <= {r_q[QB-2:0], ge};
                    r_nlo   <= r_nlo << 1;
                    r_i     <= r_i - 1'b1;
                    if (r_i == CNT_W'(1)) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    r_odata  <= rnd_val;
                    r_osat   <= over_rnd;
                    r_ovalid <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_ovalid <= 1'b0;
                        r_k      <= r_k + 1'b1;
                        r_state  <= (r_k == IDX_W'(15)) ? S_LOAD : S_DRD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = {r_osat, r_osing, r_oidx};
    assign m_axis_tlast  = r_olast;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("load and result phases overlap");

    a_start_cof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_cnt == IDX_W'(15)) |=> (r_state == S_RDE && r_k == '0))
        else $error("cofactor pass did not start after sixteenth word");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[IDX_W-1:0] == IDX_W'(15))))
        else $error("tlast does not match index");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_dabs))
        else $error("divider remainder not below divisor");

    a_no_div_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !r_sing)
        else $error("division started on a singular matrix");
`endif

endmodule

/* dv/matrix_inverse_4x4_tb.sv */
// Self-checking testbench for matrix_inverse_4x4: loads 4x4 Q16.16 matrices
// word by word and checks each inverse word against an exact cofactor model.
// Depends on mi4_pkg and matrix_inverse_4x4 only.
module matrix_inverse_4x4_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mi4_pkg::*;

    localparam int FRAC = DEF_FRAC_BITS;
    localparam logic [255:0] POS_LIM = 256'h7FFF_FFFF;
    localparam logic [255:0] NEG_LIM = 256'h8000_0000;

    typedef logic signed [255:0] wide_t;
    typedef struct packed {
        logic [31:0] value;
        logic [3:0]  index;
        logic        last;
        logic        singular;
        logic        saturated;
    } inv_word_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [EW-1:0]     s_axis_tdata;    // [31:0] element_value
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [EW-1:0]     m_axis_tdata;    // [31:0] result_value
    logic [USER_W-1:0] m_axis_tuser;    // [3:0] result_index, [4] singular, [5] saturated
    logic              m_axis_tlast;

    inv_word_t   inverse_q[$];
    t_elem       loaded_elems[16];
    int          load_pos;
    int          mismatches;
    bit          sender_quiet;
    bit          receiver_quiet;
    int          receiver_hold;

    matrix_inverse_4x4 dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic wide_t det3(input wide_t a[9]);
        wide_t t0, t1, t2;
        t0 = a[4] * a[8] - a[5] * a[7];
        t1 = a[3] * a[8] - a[5] * a[6];
        t2 = a[3] * a[7] - a[4] * a[6];
        return a[0] * t0 - a[1] * t1 + a[2] * t2;
    endfunction

    // Exact adjugate / determinant with round-half-away and clamp to 32 bits.
    function automatic void predict_inverse();
        wide_t m[16], adj[16], sub[9], det, num;
        logic [255:0] nabs, dabs, q, rem, lim;
        inv_word_t w;
        int n;
        bit neg;
        for (int k = 0; k < 16; k++) begin
            m[k] = $signed(loaded_elems[k]);
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                n = 0;
                for (int i = 0; i < 4; i++) begin
                    if (i == c) continue;
                    for (int j = 0; j < 4; j++) begin
                        if (j == r) continue;
                        sub[n] = m[j * 4 + i];
                        n++;
                    end
                end
                adj[c * 4 + r] = det3(sub);
                if (((r + c) & 1) != 0) adj[c * 4 + r] = -adj[c * 4 + r];
            end
        end
        det = 0;
        for (int k = 0; k < 4; k++) det = det + m[k] * adj[k * 4];
        for (int k = 0; k < 16; k++) begin
            w.index     = 4'(k);
            w.last      = (k == 15);
            w.singular  = (det == 0);
            w.saturated = 1'b0;
            if (det == 0) begin
                w.value = ((k & 3) == (k >> 2)) ? 32'(1 << FRAC) : 32'd0;
            end else begin
                num  = adj[k] <<< (2 * FRAC);
                neg  = num[255] != det[255];
                nabs = num[255] ? -num : num;
                dabs = det[255] ? -det : det;
                q    = nabs / dabs;
                rem  = nabs % dabs;
                if ((rem << 1) >= dabs) q = q + 1;
                lim = neg ? NEG_LIM : POS_LIM;
                if (q > lim) begin
                    q = lim;
                    w.saturated = 1'b1;
                end
                w.value = neg ? 32'(-q) : 32'(q);
            end
            inverse_q.push_back(w);
        end
    endfunction

    task automatic send_word(input t_elem v);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 17);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge i_clk); while (!s_axis_tready);
        loaded_elems[load_pos] = v;
        load_pos = (load_pos + 1) % 16;
        if (load_pos == 0) predict_inverse();
    endtask

    task automatic send_matrix(input t_elem mat[16]);
        for (int k = 0; k < 16; k++) send_word(mat[k]);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (inverse_q.size() != 0) @(posedge i_clk);
    endtask

    // Random matrix: 0 full range, 1 small values, 2 singular (repeated column).
    function automatic void make_matrix(input int kind, output t_elem mat[16]);
        int src, dst;
        for (int k = 0; k < 16; k++) begin
            mat[k] = (kind == 1) ? t_elem'($urandom_range(0, 32'h8_0000) - 32'h4_0000)
                                 : t_elem'($urandom);
        end
        if (kind == 2) begin
            src = $urandom_range(0, 3);
            dst = (src + $urandom_range(1, 3)) % 4;
            for (int r = 0; r < 4; r++) mat[dst * 4 + r] = mat[src * 4 + r];
        end
    endfunction

    // Receiver: random stalls per word, plus an optional long hold-off.
    initial begin
        int gap;
        inv_word_t got, exp_w;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = receiver_quiet ? 0 : $urandom_range(0, 17);
            if (receiver_hold > 0) begin
                gap = receiver_hold;
                receiver_hold = 0;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got = '{m_axis_tdata, m_axis_tuser[3:0], m_axis_tlast,
                    m_axis_tuser[4], m_axis_tuser[5]};
            if (inverse_q.size() == 0) begin
                $error("unexpected result word %h", got.value);
                mismatches++;
            end else begin
                exp_w = inverse_q.pop_front();
                if (got.value !== exp_w.value) begin
                    $error("result_value exp %h got %h", exp_w.value, got.value);
                    mismatches++;
                end
                if (got.index !== exp_w.index) begin
                    $error("result_index exp %0d got %0d", exp_w.index, got.index);
                    mismatches++;
                end
                if (got.last !== exp_w.last) begin
                    $error("last_result exp %b got %b", exp_w.last, got.last);
                    mismatches++;
                end
                if (got.singular !== exp_w.singular) begin
                    $error("singular exp %b got %b", exp_w.singular, got.singular);
                    mismatches++;
                end
                if (got.saturated !== exp_w.saturated) begin
                    $error("saturated exp %b got %b", exp_w.saturated, got.saturated);
                    mismatches++;
                end
            end
        end
    end

    // Extremes on the diagonal (tiny entry saturates), the zero matrix, then an upper triangular one.
    task automatic test_directed();
        t_elem mat[16];
        mat = '{default: '0};
        mat[0]  = 32'h7FFF_FFFF;
        mat[5]  = 32'h8000_0000;
        mat[10] = 32'h0000_0001;
        mat[15] = 32'hFFFF_FFFF;
        send_matrix(mat);
        mat = '{default: '0};
        send_matrix(mat);
        mat = '{default: '0};
        mat[0] = 32'h0001_0000;
        mat[5] = 32'h0002_0000;
        mat[10] = 32'hFFFF_0000;
        mat[15] = 32'h0000_8000;
        mat[4] = 32'h0003_0000;
        send_matrix(mat);
    endtask

    task automatic test_random_matrices(input int count);
        t_elem mat[16];
        for (int i = 0; i < count; i++) begin
            sender_quiet   = (i % 4 == 3);
            receiver_quiet = (i % 4 == 2);
            make_matrix((i % 5 == 4) ? 2 : i % 2, mat);
            send_matrix(mat);
        end
        sender_quiet   = 0;
        receiver_quiet = 0;
    endtask

    // Hold the output long enough that the block fills and blocks its input.
    task automatic test_output_backpressure();
        t_elem mat[16];
        receiver_hold = 4000;
        make_matrix(1, mat);
        send_matrix(mat);
        make_matrix(0, mat);
        send_matrix(mat);
    endtask

    task automatic test_drain_pause();
        t_elem mat[16];
        wait_drained();
        make_matrix(1, mat);
        send_matrix(mat);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        load_pos       = 0;
        mismatches     = 0;
        sender_quiet   = 0;
        receiver_quiet = 0;
        receiver_hold  = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_output_backpressure();
        test_drain_pause();
        test_random_matrices(4);

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && inverse_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* matrix_inverse_4x4.f */
rtl/mi4_pkg.sv
rtl/matrix_inverse_4x4.sv
dv/matrix_inverse_4x4_tb.sv
